[sv/ceqs_pkg.sv]
`timescale 1ns / 1ps
package ceqs_pkg;
  localparam int CLK_DEPTH = 16;
  localparam int TRG_DEPTH = 16;
  localparam int CLK_AW = $clog2(CLK_DEPTH);
  localparam int TRG_AW = $clog2(TRG_DEPTH);

  localparam logic [2:0] ACT_EDGE = 3'd0;
  localparam logic [2:0] ACT_POP_CLK = 3'd1;
  localparam logic [2:0] ACT_POP_TRG = 3'd2;
  localparam logic [2:0] ACT_DIAG = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  localparam logic [3:0] DG_IRQ = 4'd0;
  localparam logic [3:0] DG_ACC = 4'd1;
  localparam logic [3:0] DG_IGN = 4'd2;
  localparam logic [3:0] DG_CLKOVF = 4'd3;
  localparam logic [3:0] DG_LAST = 4'd4;
  localparam logic [3:0] DG_MIN = 4'd5;
  localparam logic [3:0] DG_MAX = 4'd6;
  localparam logic [3:0] DG_AVG = 4'd7;
  localparam logic [3:0] DG_BPM = 4'd8;
  localparam logic [3:0] DG_QUEUED = 4'd9;
  localparam logic [3:0] DG_TRGOVF = 4'd10;

  localparam logic [31:0] LIMIT_DEFAULT = 32'd500;
  localparam logic [63:0] BPM_NUM = 64'd600000000;
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;
endpackage

[sv/ceqs_ram.sv]
`timescale 1ns / 1ps
module ceqs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[sv/ceqs_div.sv]
`timescale 1ns / 1ps
module ceqs_div (
  input  logic                clk,
  input  logic                rst_n,
  input  ceqs_pkg::div_req_t  req,
  output ceqs_pkg::div_rsp_t  rsp
);
  import ceqs_pkg::*;

  logic [63:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[31:0], quo_r[63]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = trial - {1'b0, dsr_r};
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r == 7'd1 && !req.start |=> done_r && !busy_r)
    else $error("divider did not finish");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !($past(busy_r) && !done_r && !$past(req.start)) || cnt_r == 7'd0)
    else $error("divider stopped early");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("done held");
endmodule

[sv/clock_edge_qualifier_stats.sv]
`timescale 1ns / 1ps
// Clock edge qualifier with interval statistics.
// Input channel (in_*): one request per item: an edge, a pop of the clock or
// trigger queue, a diagnostic read or a clear. Result channel (out_*): exactly
// one result per request, valid/ready.
// One request is in work at a time. Edges, pops and clears pass the read
// state (queue memory read, update) and the done state. A diagnostic read
// of the average or bpm x10 with a nonzero divisor also runs the shared
// serial divider (64 steps) in the divide state; other words skip it.
// The queues sit in single-port-write synchronous RAMs; statistics and
// pointers are flops. A new request is taken as soon as the previous result
// has moved into the output register, so a stalled receiver holds one result
// while the next request is accepted and worked; the block waits only when a
// second result is ready. Reset (rst_n, synchronous) clears pointers,
// counters and statistics and sets the limit to 500; queue RAM contents are
// left as they are. The limit register sits at cfg address 0.
module clock_edge_qualifier_stats (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [1:0]  in_pin,
  input  logic        in_falling,
  input  logic [63:0] in_timestamp_us,
  input  logic [3:0]  in_diag_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [63:0] out_event_time_us,
  output logic [1:0]  out_source_pin,
  output logic [31:0] out_diag_value,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ceqs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]  st_r, st_nxt;
  logic [2:0]  act_r;
  logic [1:0]  pin_r;
  logic        fall_r;
  logic [63:0] ts_r;
  logic [3:0]  idx_r;
  logic        bpm_r;

  logic [31:0] limit_r;
  logic [CLK_AW-1:0] chead_r, ctail_r;
  logic [TRG_AW-1:0] thead_r, ttail_r;
  logic [31:0] c_irq_r, c_acc_r, c_ign_r, c_cov_r, c_tov_r;
  logic [63:0] last_t_r;
  logic [31:0] iv_min_r, iv_max_r, iv_cnt_r, iv_last_r;
  logic [63:0] iv_sum_r;

  logic        ovld_r;
  logic        o_ok_r;
  logic [63:0] o_time_r;
  logic [1:0]  o_src_r;
  logic [31:0] o_diag_r;

  logic        res_ok;
  logic [63:0] res_time;
  logic [1:0]  res_src;
  logic [31:0] res_diag;

  logic        res_ok_r;
  logic [63:0] res_time_r;
  logic [1:0]  res_src_r;
  logic [31:0] res_diag_r;

  logic        accept;
  logic [63:0] clk_rdata;
  logic [65:0] trg_rdata;
  logic        clk_we, trg_we;
  div_req_t    dreq;
  div_rsp_t    drsp;

  assign accept   = in_valid && in_ready;
  assign in_ready = (st_r == ST_IDLE);

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? limit_r : 32'd0;

  // queue memories
  ceqs_ram #(.Width(64), .Depth(CLK_DEPTH)) u_clk_ram (
    .clk, .we(clk_we), .waddr(chead_r), .wdata(ts_r), .raddr(ctail_r),
    .rdata(clk_rdata));
  ceqs_ram #(.Width(66), .Depth(TRG_DEPTH)) u_trg_ram (
    .clk, .we(trg_we), .waddr(thead_r), .wdata({pin_r, ts_r}), .raddr(ttail_r),
    .rdata(trg_rdata));

  ceqs_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  // interval and queue status
  logic [63:0] delta;
  logic [31:0] iv;
  logic        has_last, rej, c_full, t_full, do_clk, do_trg;
  logic [CLK_AW-1:0] chead_inc, q_fill;
  logic [TRG_AW-1:0] thead_inc;
  assign delta     = ts_r - last_t_r;
  assign iv        = (delta[63:32] != 32'd0) ? SAT32 : delta[31:0];
  assign has_last  = (last_t_r != 64'd0);
  assign rej       = has_last && (iv < limit_r);
  assign chead_inc = chead_r + 1'b1;
  assign thead_inc = thead_r + 1'b1;
  assign q_fill    = chead_r - ctail_r;
  assign c_full    = (chead_inc == ctail_r);
  assign t_full    = (thead_inc == ttail_r);
  assign do_clk    = (st_r == ST_READ) && act_r == ACT_EDGE && fall_r && pin_r == 2'd0;
  assign do_trg    = (st_r == ST_READ) && act_r == ACT_EDGE && fall_r && pin_r != 2'd0;
  assign clk_we    = do_clk && !rej && !c_full;
  assign trg_we    = do_trg && !t_full;

  // divider request for average or bpm
  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = BPM_NUM;
    dreq.divisor  = iv_last_r;
    if (st_r == ST_READ && act_r == ACT_DIAG) begin
      if (idx_r == DG_AVG && iv_cnt_r != 32'd0) begin
        dreq.start    = 1'b1;
        dreq.dividend = iv_sum_r;
        dreq.divisor  = iv_cnt_r;
      end else if (idx_r == DG_BPM && iv_last_r != 32'd0) begin
        dreq.start = 1'b1;
      end
    end
  end

  // result for the request in work, valid in the read stage
  always_comb begin
    res_ok   = 1'b0;
    res_time = '0;
    res_src  = '0;
    res_diag = '0;
    case (act_r)
      ACT_POP_CLK: if (ctail_r != chead_r) begin
        res_ok   = 1'b1;
        res_time = clk_rdata;
      end
      ACT_POP_TRG: if (ttail_r != thead_r) begin
        res_ok   = 1'b1;
        res_time = trg_rdata[63:0];
        res_src  = trg_rdata[65:64];
      end
      ACT_DIAG: begin
        res_ok = 1'b1;
        unique case (idx_r)
          DG_IRQ:    res_diag = c_irq_r;
          DG_ACC:    res_diag = c_acc_r;
          DG_IGN:    res_diag = c_ign_r;
          DG_CLKOVF: res_diag = c_cov_r;
          DG_LAST:   res_diag = iv_last_r;
          DG_MIN:    res_diag = iv_min_r;
          DG_MAX:    res_diag = iv_max_r;
          DG_AVG, DG_BPM: res_diag = '0;
          DG_QUEUED: res_diag = 32'(q_fill);
          DG_TRGOVF: res_diag = c_tov_r;
          default:   res_ok = 1'b0;
        endcase
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (accept) st_nxt = ST_READ;
      ST_READ: st_nxt = dreq.start ? ST_DIV : ST_DONE;
      ST_DIV:  if (drsp.done) st_nxt = ST_DONE;
      ST_DONE: if (!ovld_r || out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  logic load_out;
  logic [31:0] div_val;
  assign load_out = (st_r == ST_DONE) && (!ovld_r || out_ready);
  always_comb begin
    if (bpm_r) div_val = {16'd0, drsp.quotient[15:0]};
    else div_val = (drsp.quotient[63:32] != 32'd0) ? SAT32 : drsp.quotient[31:0];
  end

  logic [31:0] div_hold_r;
  logic        div_used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      ovld_r     <= 1'b0;
      limit_r    <= LIMIT_DEFAULT;
      div_used_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load_out) ovld_r <= 1'b1;
      else if (out_ready) ovld_r <= 1'b0;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
        limit_r <= (cfg_pwdata == 32'd0) ? LIMIT_DEFAULT : cfg_pwdata;
      if (st_r == ST_READ) div_used_r <= dreq.start;
    end
    if (accept) begin
      act_r  <= in_action;
      pin_r  <= in_pin;
      fall_r <= in_falling;
      ts_r   <= in_timestamp_us;
      idx_r  <= in_diag_index;
    end
    // hold the result while pointers move on and the receiver stalls
    if (st_r == ST_READ) begin
      bpm_r      <= (idx_r == DG_BPM);
      res_ok_r   <= res_ok;
      res_time_r <= res_time;
      res_src_r  <= res_src;
      res_diag_r <= res_diag;
    end
    if (drsp.done) div_hold_r <= div_val;
    if (load_out) begin
      o_ok_r   <= res_ok_r;
      o_time_r <= res_time_r;
      o_src_r  <= res_src_r;
      o_diag_r <= div_used_r ? div_hold_r : res_diag_r;
    end
  end

  // state update at the read stage
  always_ff @(posedge clk) begin
    if (!rst_n || (st_r == ST_READ && act_r == ACT_CLEAR)) begin
      chead_r <= '0; ctail_r <= '0; thead_r <= '0; ttail_r <= '0;
      c_irq_r <= '0; c_acc_r <= '0; c_ign_r <= '0; c_cov_r <= '0; c_tov_r <= '0;
      last_t_r <= '0; iv_min_r <= '0; iv_max_r <= '0; iv_cnt_r <= '0;
      iv_last_r <= '0; iv_sum_r <= '0;
    end else if (st_r == ST_READ) begin
      if (do_clk) begin
        c_irq_r <= c_irq_r + 32'd1;
        if (rej) c_ign_r <= c_ign_r + 32'd1;
        else begin
          if (has_last) begin
            iv_last_r <= iv;
            if (iv_min_r == 32'd0 || iv < iv_min_r) iv_min_r <= iv;
            if (iv > iv_max_r) iv_max_r <= iv;
            iv_sum_r <= iv_sum_r + {32'd0, iv};
            iv_cnt_r <= iv_cnt_r + 32'd1;
          end
          last_t_r <= ts_r;
          if (c_full) c_cov_r <= c_cov_r + 32'd1;
          else begin
            chead_r <= chead_inc;
            c_acc_r <= c_acc_r + 32'd1;
          end
        end
      end
      if (do_trg) begin
        if (t_full) c_tov_r <= c_tov_r + 32'd1;
        else thead_r <= thead_inc;
      end
      if (act_r == ACT_POP_CLK && ctail_r != chead_r) ctail_r <= ctail_r + 1'b1;
      if (act_r == ACT_POP_TRG && ttail_r != thead_r) ttail_r <= ttail_r + 1'b1;
    end
  end

  assign out_valid          = ovld_r;
  assign out_ok             = o_ok_r;
  assign out_event_time_us  = o_time_r;
  assign out_source_pin     = o_src_r;
  assign out_diag_value     = o_diag_r;

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> st_r == ST_READ)
    else $error("request not started");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && !out_ready |=> ovld_r && $stable(o_time_r))
    else $error("result lost");
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    clk_we |-> !c_full)
    else $error("push into full clock queue");
  a_lim_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    limit_r != 32'd0)
    else $error("zero limit");
endmodule
